// File: sv/bed_pkg.sv
// Shared constants, types and saturation arithmetic for the echo delay block.
`timescale 1ns / 1ps
package bed_pkg;

   localparam int BLOCK_LEN = 256;
   localparam int SLOTS     = 8;
   localparam int DEPTH     = BLOCK_LEN * SLOTS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int POS_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int FILL_W    = $clog2(DEPTH + 1);

   localparam int SAMPLE_W  = 12;
   localparam int POT_W     = 12;
   localparam int OUT_W     = 16;
   localparam int REC_SHIFT = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_BIAS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_BIAS = 2'd2;

   localparam logic                  ECHO_ENABLE_RST = 1'b0;
   localparam logic [SAMPLE_W-1:0]   INPUT_BIAS_RST  = 12'h800;
   localparam logic [OUT_W-1:0]      OUTPUT_BIAS_RST = 16'h4000;

   typedef logic signed [OUT_W-1:0] sample_type;

   typedef struct packed {
      logic       bypass;
      logic       stored;
      logic       echo;
      sample_type x;
   } stage_type;

   function automatic sample_type sat_add(input sample_type a, input sample_type b);
      logic signed [OUT_W:0] s;
      s = {a[OUT_W-1], a} + {b[OUT_W-1], b};
      if (s[OUT_W] != s[OUT_W-1])
         return s[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      else
         return s[OUT_W-1:0];
   endfunction

endpackage

// File: sv/bed_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/block_echo_delay.sv
// Top level of the block echo delay: recentring, delay store, echo mix and output bias.
//
// Input channel req_*: one transfer per audio frame, carrying the raw audio
// sample and the raw pot reading (the pot is latched on the first frame of
// each block). Result channel rsp_*: one transfer per frame, the signed Q15
// output sample, in frame order.
// Throughput: one frame per cycle while the receiver accepts results. The path
// to rsp_valid runs through the registered read of the delay memory (one write
// and one read port, both used at the input transfer) followed by the mix register.
// Configuration (csr_*) is written while no frame is in flight; index 0 is
// echo enable, 1 the input bias, 2 the output bias; other indexes are ignored.
// Reset: synchronous, clears the pipeline, block position, write slot, latched
// pot and restores the register defaults. The delay store reads as zero until
// written, tracked by a fill count, so no clearing pass is needed after reset.
// When the receiver stalls, the result is held in the output register, one more
// frame may enter the mix stage, and req_ready then drops until space frees up.
`timescale 1ns / 1ps
module block_echo_delay
   import bed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_audio_sample,
   input  logic [POT_W-1:0]      req_pot_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [OUT_W-1:0] rsp_out_sample,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                echo_en_ff;
   logic [SAMPLE_W-1:0] in_bias_ff;
   sample_type          out_bias_ff;

   logic [POS_W-1:0]    pos_ff,    pos_in;
   logic [SLOT_W-1:0]   slot_ff,   slot_in;
   logic [SLOT_W-1:0]   offset_ff, offset_in;
   logic [FILL_W-1:0]   fill_ff,   fill_in;

   logic                s1_vld_ff, s1_vld_in;
   stage_type           s1_ff,     s1_in;
   logic                rsp_vld_ff, rsp_vld_in;
   sample_type          rsp_ff,     rsp_in;

   logic                req_xfer;
   logic                rsp_free;
   logic [POT_W+SLOT_W-1:0] pot_scaled;
   logic [SLOT_W:0]     slot_sum;
   logic [SLOT_W:0]     slot_wrap;
   logic [SLOT_W-1:0]   rd_slot;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic signed [SAMPLE_W:0] diff;
   sample_type          x_new;
   sample_type          ram_q;
   sample_type          delayed;
   sample_type          mixed;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_en_ff  <= ECHO_ENABLE_RST;
         in_bias_ff  <= INPUT_BIAS_RST;
         out_bias_ff <= OUTPUT_BIAS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ECHO_ENABLE: echo_en_ff  <= csr_wdata[0];
            CSR_INPUT_BIAS:  in_bias_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_OUTPUT_BIAS: out_bias_ff <= csr_wdata[OUT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_free  = !rsp_vld_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || rsp_free;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      pot_scaled = (POT_W+SLOT_W)'(req_pot_sample) * (POT_W+SLOT_W)'(SLOTS);
      offset_in  = (pos_ff == '0) ? pot_scaled[POT_W +: SLOT_W] : offset_ff;
      slot_sum   = {1'b0, offset_in} + {1'b0, slot_ff};
      slot_wrap  = (slot_sum >= (SLOT_W+1)'(SLOTS)) ? slot_sum - (SLOT_W+1)'(SLOTS) : slot_sum;
      rd_slot    = slot_wrap[SLOT_W-1:0];
      wr_addr    = ADDR_W'(slot_ff) * ADDR_W'(BLOCK_LEN) + ADDR_W'(pos_ff);
      rd_addr    = ADDR_W'(rd_slot) * ADDR_W'(BLOCK_LEN) + ADDR_W'(pos_ff);

      diff  = $signed({1'b0, req_audio_sample}) - $signed({1'b0, in_bias_ff});
      x_new = {diff, {REC_SHIFT{1'b0}}};

      s1_in.bypass = (rd_slot == slot_ff);
      s1_in.stored = (FILL_W'(rd_addr) < fill_ff);
      s1_in.echo   = echo_en_ff;
      s1_in.x      = x_new;

      pos_in  = pos_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (req_xfer) begin
         if (pos_ff == POS_W'(BLOCK_LEN - 1)) begin
            pos_in  = '0;
            slot_in = (slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : slot_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
         if (fill_ff != FILL_W'(DEPTH))
            fill_in = fill_ff + 1'b1;
      end

      s1_vld_in = req_xfer ? 1'b1 : (rsp_free ? 1'b0 : s1_vld_ff);

      if (s1_ff.bypass)
         delayed = s1_ff.x;
      else if (s1_ff.stored)
         delayed = ram_q;
      else
         delayed = '0;
      mixed  = s1_ff.echo ? sat_add(s1_ff.x, delayed) : s1_ff.x;
      rsp_in = sat_add(mixed, out_bias_ff);

      rsp_vld_in = rsp_free ? s1_vld_ff : rsp_vld_ff;
   end

   // frame counters and latched pot select
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         slot_ff   <= '0;
         offset_ff <= '0;
         fill_ff   <= '0;
      end else begin
         pos_ff  <= pos_in;
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         if (req_xfer)
            offset_ff <= offset_in;
      end
   end

   // mix stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      if (req_xfer)
         s1_ff <= s1_in;
      if (rsp_free && s1_vld_ff)
         rsp_ff <= rsp_in;
   end

   bed_ram #(
      .WIDTH (OUT_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (wr_addr),
      .wr_data (x_new),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_out_sample = rsp_ff;

endmodule

// File: sv/bed_checker.sv
// Port-level checks for the block echo delay, bound to the top level.
`timescale 1ns / 1ps
module bed_checker
   import bed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic signed [OUT_W-1:0] rsp_out_sample
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pend_ff, pend_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer)
         pend_in = pend_ff + 1'b1;
      else if (!req_xfer && rsp_xfer)
         pend_in = pend_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         pend_ff <= '0;
      else
         pend_ff <= pend_in;
   end

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two frames in flight");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result offered with no frame in flight");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd0 |-> req_ready)
      else $error("input stalled while empty");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && pend_ff == 2'd0) |=> ##1 rsp_valid)
      else $error("result late on an empty pipeline");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_sample)))
      else $error("stalled result changed");

endmodule

bind block_echo_delay bed_checker u_bed_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_sample   (rsp_out_sample)
);

// File: sim/block_echo_delay_tb.sv
// Testbench for block_echo_delay: directed table then random frames, checked against a predictor.
`timescale 1ns / 1ps
module block_echo_delay_tb
   import bed_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT = 4000;
   localparam int ROWS = 30;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [SAMPLE_W-1:0]   audio;
      logic [POT_W-1:0]      pot;
      logic                  known;
      sample_type            want;
   } stim_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_audio_sample = '0;
   logic [POT_W-1:0]      req_pot_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_out_sample;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state and register copy
   sample_type          echo_store [DEPTH];
   int                  wr_slot;
   int                  blk_pos;
   logic [POT_W-1:0]    held_pot;
   logic                echo_on;
   logic [SAMPLE_W-1:0] in_bias;
   sample_type          out_bias;

   sample_type pending_out [$];
   int         mismatches = 0;
   int         stall_cycles = 0;
   bit         steady = 1'b0;

   stim_row_type script [ROWS] = '{
      '{ROW_FRAME, '0, '0, 12'd2048, 12'h000, 1'b1, 16'sd16384},
      '{ROW_FRAME, '0, '0, 12'd0,    12'hFFF, 1'b1, 16'sd0},
      '{ROW_FRAME, '0, '0, 12'd4095, 12'h000, 1'b1, 16'sd32760},
      '{ROW_CSR, CSR_OUTPUT_BIAS, 16'h7FFF, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd4095, 12'h555, 1'b1, 16'sd32767},
      '{ROW_FRAME, '0, '0, 12'd0,    12'hAAA, 1'b1, 16'sd16383},
      '{ROW_CSR, CSR_OUTPUT_BIAS, 16'h8000, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd0,    12'hFFF, 1'b1, 16'sh8000},
      '{ROW_FRAME, '0, '0, 12'd4095, 12'h000, 1'b1, -16'sd16392},
      '{ROW_CSR, CSR_INPUT_BIAS, 16'h0000, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd4095, 12'h800, 1'b1, -16'sd8},
      '{ROW_FRAME, '0, '0, 12'd0,    12'h7FF, 1'b1, 16'sh8000},
      '{ROW_CSR, CSR_INPUT_BIAS, 16'h0FFF, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd0,    12'h000, 1'b1, 16'sh8000},
      '{ROW_CSR, CSR_OUTPUT_BIAS, 16'h0000, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd0,    12'hFFF, 1'b1, -16'sd32760},
      '{ROW_FRAME, '0, '0, 12'd4095, 12'h000, 1'b1, 16'sd0},
      '{ROW_CSR, CSR_SPARE, 16'hFFFF, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd2047, 12'h123, 1'b1, -16'sd16384},
      '{ROW_CSR, CSR_ECHO_ENABLE, 16'h0001, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd0,    12'h000, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd4095, 12'hFFF, 1'b0, '0},
      '{ROW_CSR, CSR_INPUT_BIAS, 16'h0000, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd4095, 12'h000, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd1,    12'hFFF, 1'b0, '0},
      '{ROW_CSR, CSR_INPUT_BIAS, 16'h0800, '0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_OUTPUT_BIAS, 16'h4000, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd2048, 12'h456, 1'b0, '0},
      '{ROW_CSR, CSR_ECHO_ENABLE, 16'h0000, '0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 12'd1000, 12'h000, 1'b0, '0}
   };

   block_echo_delay dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_audio_sample (req_audio_sample),
      .req_pot_sample   (req_pot_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_sample   (rsp_out_sample),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic sample_type clamp16(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[OUT_W-1:0];
   endfunction

   function automatic sample_type predict_out_sample(input logic [SAMPLE_W-1:0] audio,
                                                     input logic [POT_W-1:0] pot);
      int recentred;
      int tap_slot;
      int mixed;
      if (blk_pos == 0) held_pot = pot;
      recentred = (int'(audio) - int'(in_bias)) * 8;
      echo_store[wr_slot * BLOCK_LEN + blk_pos] = clamp16(recentred);
      mixed = recentred;
      if (echo_on) begin
         tap_slot = (((int'(held_pot) * SLOTS) >> POT_W) + wr_slot) % SLOTS;
         mixed = clamp16(mixed + int'(echo_store[tap_slot * BLOCK_LEN + blk_pos]));
      end
      mixed = clamp16(mixed + int'(out_bias));
      blk_pos++;
      if (blk_pos == BLOCK_LEN) begin
         blk_pos = 0;
         wr_slot = (wr_slot + 1) % SLOTS;
      end
      return mixed[OUT_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input sample_type got,
                                  input sample_type want);
      $display("tb: mismatch (%s) out_sample got %0d want %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   task automatic send_frame(input logic [SAMPLE_W-1:0] audio, input logic [POT_W-1:0] pot,
                             input logic known, input sample_type want);
      sample_type predicted;
      while (!steady && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_audio_sample <= audio;
      req_pot_sample   <= pot;
      do @(posedge clock); while (!req_ready);
      predicted = predict_out_sample(audio, pot);
      pending_out.push_back(known ? want : predicted);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      unique case (idx)
         CSR_ECHO_ENABLE: echo_on = data[0];
         CSR_INPUT_BIAS:  in_bias = data[SAMPLE_W-1:0];
         CSR_OUTPUT_BIAS: out_bias = data[OUT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin : rsp_side
      sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out.size() == 0) begin
            report_mismatch("no frame pending", rsp_out_sample, '0);
         end else begin
            want = pending_out.pop_front();
            if (rsp_out_sample !== want) report_mismatch("value", rsp_out_sample, want);
         end
      end
      rsp_ready <= steady || ($urandom_range(99) >= 13);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int                  frames;
      logic [SAMPLE_W-1:0] audio;
      logic [POT_W-1:0]    pot;
      logic [CSR_DATA_W-1:0] value;
      for (int i = 0; i < DEPTH; i++) echo_store[i] = '0;
      wr_slot  = 0;
      blk_pos  = 0;
      held_pot = '0;
      echo_on  = ECHO_ENABLE_RST;
      in_bias  = INPUT_BIAS_RST;
      out_bias = OUTPUT_BIAS_RST;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < ROWS; r++) begin
         if (script[r].kind == ROW_CSR) begin
            drain();
            write_csr(script[r].idx, script[r].data);
         end else begin
            send_frame(script[r].audio, script[r].pot, script[r].known, script[r].want);
         end
      end

      for (int phase = 0; phase < 13; phase++) begin
         drain();
         write_csr(CSR_ECHO_ENABLE, 16'($urandom_range(3) != 0));
         case ($urandom_range(3))
            0: value = 16'h0000;
            1: value = 16'h0FFF;
            2: value = 16'h0800;
            default: value = 16'($urandom);
         endcase
         write_csr(CSR_INPUT_BIAS, value);
         case ($urandom_range(3))
            0: value = 16'h7FFF;
            1: value = 16'h8000;
            2: value = 16'h0000;
            default: value = 16'($urandom);
         endcase
         write_csr(CSR_OUTPUT_BIAS, value);
         if ($urandom_range(3) == 0) write_csr(CSR_SPARE, 16'($urandom));
         steady = (phase == 5);
         frames = $urandom_range(120, 180);
         for (int n = 0; n < frames; n++) begin
            if ($urandom_range(7) == 0) audio = $urandom_range(1) ? 12'hFFF : 12'h000;
            else audio = 12'($urandom);
            // favour the zero-offset tap on block starts
            if (blk_pos == 0 && $urandom_range(3) == 0) pot = 12'($urandom_range(511));
            else pot = 12'($urandom);
            send_frame(audio, pot, 1'b0, '0);
         end
      end
      steady = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_out.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
